/* design/scov_pkg.sv */
// types and constants shared by the splat covariance pipeline
// used by scov_div and splat_covariance_from_quat_scale
`timescale 1ns / 1ps
`default_nettype none

package scov_pkg;

  localparam int unsigned NUM_ENT     = 9;
  localparam int unsigned N_W         = 33;
  localparam int unsigned QUO_W       = 31;
  localparam int unsigned STEPS_PER   = 2;
  localparam int unsigned DIV_STAGES  = 1 + (QUO_W + STEPS_PER - 1) / STEPS_PER;
  localparam int unsigned NUM_STAGES  = 4 + DIV_STAGES + 4;
  localparam logic [N_W-1:0] QLEN_EPS = 33'd32;
  localparam logic [N_W-1:0] N_UNIT   = 33'd268435456;

  typedef logic [N_W-1:0]   len_t;
  typedef logic [N_W-1:0]   rem_t;
  typedef logic [QUO_W-1:0] quo_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [63:0]        color;
    logic [23:0]        sx;
    logic [23:0]        sy;
    logic [23:0]        sz;
  } side_t;

endpackage

`default_nettype wire

/* design/scov_div.sv */
// pipelined restoring divider for the nine rotation entries, two quotient bits a stage
// depends on scov_pkg
`timescale 1ns / 1ps
`default_nettype none

module scov_div (
  input  wire logic                            clk_i,
  input  wire logic [scov_pkg::DIV_STAGES-1:0] en_i,
  input  wire scov_pkg::len_t                  n_i,
  input  wire scov_pkg::len_t                  mag_i [scov_pkg::NUM_ENT],
  input  wire logic [scov_pkg::NUM_ENT-1:0]    neg_i,
  output      scov_pkg::quo_t                  quo_o [scov_pkg::NUM_ENT],
  output      logic [scov_pkg::NUM_ENT-1:0]    neg_o
);
  import scov_pkg::*;

  rem_t                rem_q [DIV_STAGES][NUM_ENT];
  quo_t                low_q [DIV_STAGES][NUM_ENT];
  quo_t                quo_q [DIV_STAGES][NUM_ENT];
  logic [NUM_ENT-1:0]  neg_q [DIV_STAGES];
  len_t                n_q   [DIV_STAGES];

  // stage 0 forms the rounded dividend
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int e = 0; e < NUM_ENT; e++) begin
        logic [62:0] dvd;
        dvd = {mag_i[e][32:0], 30'b0} + 63'(n_i[N_W-1:1]);
        rem_q[0][e] <= {1'b0, dvd[62:31]};
        low_q[0][e] <= dvd[30:0];
        quo_q[0][e] <= '0;
      end
      neg_q[0] <= neg_i;
      n_q[0]   <= n_i;
    end
  end

  for (genvar s = 1; s < DIV_STAGES; s++) begin : g_st
    rem_t rem_d [NUM_ENT];
    quo_t low_d [NUM_ENT];
    quo_t quo_d [NUM_ENT];

    always_comb begin
      logic [N_W:0] t;
      for (int e = 0; e < NUM_ENT; e++) begin
        rem_d[e] = rem_q[s-1][e];
        low_d[e] = low_q[s-1][e];
        quo_d[e] = quo_q[s-1][e];
        for (int j = 0; j < STEPS_PER; j++) begin
          t = '0;
          if ((s - 1) * STEPS_PER + j < QUO_W) begin
            t = {rem_d[e], low_d[e][QUO_W-1]};
            low_d[e] = {low_d[e][QUO_W-2:0], 1'b0};
            if (t >= {1'b0, n_q[s-1]}) begin
              rem_d[e] = N_W'(t - {1'b0, n_q[s-1]});
              quo_d[e] = {quo_d[e][QUO_W-2:0], 1'b1};
            end else begin
              rem_d[e] = t[N_W-1:0];
              quo_d[e] = {quo_d[e][QUO_W-2:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= rem_d;
        low_q[s] <= low_d;
        quo_q[s] <= quo_d;
        neg_q[s] <= neg_q[s-1];
        n_q[s]   <= n_q[s-1];
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];
  assign neg_o = neg_q[DIV_STAGES-1];

endmodule

`default_nettype wire

/* design/splat_covariance_from_quat_scale.sv */
// sustains one word per cycle from input to output while the output is not stalled
// the exact 31-bit division of the nine rotation entries sets the depth (16 step stages)
// each stage moves when it is empty or the stage after it moves, so bubbles close up
// reset clears all stage valid bits and the axis-flip register
// top level of the splat covariance pipeline
// depends on scov_pkg and scov_div
`timescale 1ns / 1ps
`default_nettype none

module splat_covariance_from_quat_scale (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic [23:0]        scale_x_i,
  input  wire logic [23:0]        scale_y_i,
  input  wire logic [23:0]        scale_z_i,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  input  wire logic [63:0]        color_alpha_in_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [31:0] center_x_o,
  output      logic signed [31:0] center_y_o,
  output      logic signed [31:0] center_z_o,
  output      logic signed [63:0] cov_xx_o,
  output      logic signed [63:0] cov_xy_o,
  output      logic signed [63:0] cov_xz_o,
  output      logic signed [63:0] cov_yy_o,
  output      logic signed [63:0] cov_yz_o,
  output      logic signed [63:0] cov_zz_o,
  output      logic [63:0]        color_alpha_out_o
);
  import scov_pkg::*;

  localparam int unsigned SD = 4;
  localparam int unsigned SM = SD + DIV_STAGES;

  function automatic logic [15:0] clamp_lane(input logic [15:0] v);
    logic [15:0] r;
    if (v[15]) begin
      r = '0;
    end else if (v > 16'd4096) begin
      r = 16'd32768;
    end else begin
      r = {v[12:0], 3'b0};
    end
    return r;
  endfunction

  logic                  flip_q;
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES:0]   en;
  side_t                 sb_q [NUM_STAGES];
  side_t                 sb_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_q <= 1'b0;
    end else if (cfg_we_i) begin
      flip_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    en[NUM_STAGES] = !out_stall_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 0: axis flip, color clamp
  logic signed [16:0] w_d, x_d, y_d, z_d;
  logic signed [16:0] w0_q, x0_q, y0_q, z0_q;

  always_comb begin
    w_d = 17'(quat_w_i);
    x_d = 17'(quat_x_i);
    y_d = 17'(quat_y_i);
    z_d = 17'(quat_z_i);
    sb_d.cx    = pos_x_i;
    sb_d.cy    = pos_y_i;
    sb_d.cz    = pos_z_i;
    sb_d.sx    = scale_x_i;
    sb_d.sy    = scale_y_i;
    sb_d.sz    = scale_z_i;
    sb_d.color = {clamp_lane(color_alpha_in_i[63:48]), clamp_lane(color_alpha_in_i[47:32]),
                  clamp_lane(color_alpha_in_i[31:16]), clamp_lane(color_alpha_in_i[15:0])};
    if (flip_q) begin
      y_d = -y_d;
      z_d = -z_d;
      sb_d.cy = (pos_y_i == 32'sh8000_0000) ? 32'sh7fff_ffff : -pos_y_i;
      sb_d.cz = (pos_z_i == 32'sh8000_0000) ? 32'sh7fff_ffff : -pos_z_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      w0_q     <= w_d;
      x0_q     <= x_d;
      y0_q     <= y_d;
      z0_q     <= z_d;
      sb_q[0]  <= sb_d;
    end
  end

  for (genvar k = 1; k < NUM_STAGES; k++) begin : g_sb
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  // stage 1: quaternion products
  logic signed [33:0] ww1_q, xx1_q, yy1_q, zz1_q, xy1_q, xz1_q, yz1_q, wx1_q, wy1_q, wz1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ww1_q <= w0_q * w0_q;
      xx1_q <= x0_q * x0_q;
      yy1_q <= y0_q * y0_q;
      zz1_q <= z0_q * z0_q;
      xy1_q <= x0_q * y0_q;
      xz1_q <= x0_q * z0_q;
      yz1_q <= y0_q * z0_q;
      wx1_q <= w0_q * x0_q;
      wy1_q <= w0_q * y0_q;
      wz1_q <= w0_q * z0_q;
    end
  end

  // stage 2: squared length
  len_t               n2_q;
  logic signed [33:0] xx2_q, yy2_q, zz2_q, xy2_q, xz2_q, yz2_q, wx2_q, wy2_q, wz2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      n2_q  <= ww1_q[32:0] + xx1_q[32:0] + yy1_q[32:0] + zz1_q[32:0];
      xx2_q <= xx1_q;
      yy2_q <= yy1_q;
      zz2_q <= zz1_q;
      xy2_q <= xy1_q;
      xz2_q <= xz1_q;
      yz2_q <= yz1_q;
      wx2_q <= wx1_q;
      wy2_q <= wy1_q;
      wz2_q <= wz1_q;
    end
  end

  // stage 3: rotation numerators, tiny quaternion gives identity
  len_t               n_t;
  logic signed [34:0] n35;
  logic signed [34:0] xx_t, yy_t, zz_t, xy_t, xz_t, yz_t, wx_t, wy_t, wz_t;
  logic signed [34:0] num [NUM_ENT];
  len_t               mag3_d [NUM_ENT];
  logic [NUM_ENT-1:0] neg3_d;
  len_t               mag3_q [NUM_ENT];
  logic [NUM_ENT-1:0] neg3_q;
  len_t               n3_q;

  always_comb begin
    logic tiny;
    logic signed [34:0] a;
    tiny = (n2_q <= QLEN_EPS);
    n_t  = tiny ? N_UNIT : n2_q;
    n35  = signed'({2'b0, n_t});
    xx_t = tiny ? '0 : 35'(xx2_q);
    yy_t = tiny ? '0 : 35'(yy2_q);
    zz_t = tiny ? '0 : 35'(zz2_q);
    xy_t = tiny ? '0 : 35'(xy2_q);
    xz_t = tiny ? '0 : 35'(xz2_q);
    yz_t = tiny ? '0 : 35'(yz2_q);
    wx_t = tiny ? '0 : 35'(wx2_q);
    wy_t = tiny ? '0 : 35'(wy2_q);
    wz_t = tiny ? '0 : 35'(wz2_q);
    num[0] = n35 - ((yy_t + zz_t) <<< 1);
    num[1] = (xy_t - wz_t) <<< 1;
    num[2] = (xz_t + wy_t) <<< 1;
    num[3] = (xy_t + wz_t) <<< 1;
    num[4] = n35 - ((xx_t + zz_t) <<< 1);
    num[5] = (yz_t - wx_t) <<< 1;
    num[6] = (xz_t - wy_t) <<< 1;
    num[7] = (yz_t + wx_t) <<< 1;
    num[8] = n35 - ((xx_t + yy_t) <<< 1);
    for (int e = 0; e < NUM_ENT; e++) begin
      a = num[e][34] ? -num[e] : num[e];
      mag3_d[e] = a[32:0];
      neg3_d[e] = num[e][34];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      mag3_q <= mag3_d;
      neg3_q <= neg3_d;
      n3_q   <= n_t;
    end
  end

  // stages 4 .. 4+DIV_STAGES-1: division by the squared length
  quo_t               quo [NUM_ENT];
  logic [NUM_ENT-1:0] qneg;

  scov_div u_div (
    .clk_i  (clk_i),
    .en_i   (en[SD +: DIV_STAGES]),
    .n_i    (n3_q),
    .mag_i  (mag3_q),
    .neg_i  (neg3_q),
    .quo_o  (quo),
    .neg_o  (qneg)
  );

  // scale multiply
  logic signed [56:0] p_q [NUM_ENT];
  side_t              sb_div;

  assign sb_div = sb_q[SM-1];

  always_ff @(posedge clk_i) begin
    if (en[SM]) begin
      for (int e = 0; e < NUM_ENT; e++) begin
        logic signed [31:0] qs;
        logic signed [24:0] sc;
        qs = qneg[e] ? -signed'({1'b0, quo[e]}) : signed'({1'b0, quo[e]});
        case (e % 3)
          0:       sc = signed'({1'b0, sb_div.sx});
          1:       sc = signed'({1'b0, sb_div.sy});
          default: sc = signed'({1'b0, sb_div.sz});
        endcase
        p_q[e] <= qs * sc;
      end
    end
  end

  // round to q8.16
  logic signed [25:0] m_q [NUM_ENT];

  always_ff @(posedge clk_i) begin
    if (en[SM+1]) begin
      for (int e = 0; e < NUM_ENT; e++) begin
        logic [56:0] pm;
        logic [56:0] r;
        pm = p_q[e][56] ? 57'(-p_q[e]) : 57'(p_q[e]);
        r  = (pm + 57'd536870912) >> 30;
        m_q[e] <= p_q[e][56] ? -signed'(r[25:0]) : signed'(r[25:0]);
      end
    end
  end

  // covariance partial products: entry c uses rows ri, rk
  logic signed [51:0] cp_q [6][3];

  always_ff @(posedge clk_i) begin
    if (en[SM+2]) begin
      for (int j = 0; j < 3; j++) begin
        cp_q[0][j] <= m_q[j]   * m_q[j];
        cp_q[1][j] <= m_q[j]   * m_q[3+j];
        cp_q[2][j] <= m_q[j]   * m_q[6+j];
        cp_q[3][j] <= m_q[3+j] * m_q[3+j];
        cp_q[4][j] <= m_q[3+j] * m_q[6+j];
        cp_q[5][j] <= m_q[6+j] * m_q[6+j];
      end
    end
  end

  // output register
  logic signed [63:0] cov_q [6];

  always_ff @(posedge clk_i) begin
    if (en[SM+3]) begin
      for (int c = 0; c < 6; c++) begin
        cov_q[c] <= 64'(cp_q[c][0]) + 64'(cp_q[c][1]) + 64'(cp_q[c][2]);
      end
    end
  end

  assign out_valid_o       = v_q[NUM_STAGES-1];
  assign center_x_o        = sb_q[NUM_STAGES-1].cx;
  assign center_y_o        = sb_q[NUM_STAGES-1].cy;
  assign center_z_o        = sb_q[NUM_STAGES-1].cz;
  assign color_alpha_out_o = sb_q[NUM_STAGES-1].color;
  assign cov_xx_o          = cov_q[0];
  assign cov_xy_o          = cov_q[1];
  assign cov_xz_o          = cov_q[2];
  assign cov_yy_o          = cov_q[3];
  assign cov_yz_o          = cov_q[4];
  assign cov_zz_o          = cov_q[5];

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output free");

  a_diag_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!cov_xx_o[63] && !cov_yy_o[63] && !cov_zz_o[63]))
    else $error("negative covariance diagonal");

  a_red_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!color_alpha_out_o[15] || color_alpha_out_o[14:0] == 15'd0))
    else $error("red lane above one");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (flip_q == $past(cfg_wdata_i)))
    else $error("flip register not written");

endmodule

`default_nettype wire
